>>> sv/tdmds_pkg.sv
// ----------------------------------------------------------------------------
// tdmds_pkg
// Shared types, constants and helpers for the three-digit display scanner.
// ----------------------------------------------------------------------------
package tdmds_pkg;

  localparam int unsigned TimeW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDig  = 3;
  localparam int unsigned SegW    = 7;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgOnTime  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgOffTime = 8'd1;

  // floor(v/10) = (v * 52429) >> 19, floor((v>>2)/25) = ((v>>2) * 20972) >> 19
  localparam logic [16:0] Recip10  = 17'd52429;
  localparam logic [14:0] Recip25  = 15'd20972;
  localparam int unsigned RecipSh  = 19;

  typedef enum logic [2:0] {
    PH_DIGIT1 = 3'd0,
    PH_GAP1   = 3'd1,
    PH_DIGIT2 = 3'd2,
    PH_GAP2   = 3'd3,
    PH_DIGIT3 = 3'd4,
    PH_GAP3   = 3'd5
  } phase_e;

  function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] d);
    logic [SegW-1:0] p;
    unique case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h27;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h67;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  // x mod 10 from x mod 2 and x mod 5; 16 = 1 (mod 5) so nibbles add up.
  function automatic logic [DigitW-1:0] dec_digit(input logic [ValueW-1:0] x);
    logic [5:0] nsum;
    logic [4:0] fold;
    logic [4:0] r;
    logic [3:0] r5;
    nsum = 6'({2'b00, x[3:0]}) + 6'({2'b00, x[7:4]})
         + 6'({2'b00, x[11:8]}) + 6'({2'b00, x[15:12]});
    fold = 5'({3'b000, nsum[5:4]}) + 5'({1'b0, nsum[3:0]});
    r    = fold;
    if (r >= 5'd15) begin
      r = r - 5'd15;
    end else if (r >= 5'd10) begin
      r = r - 5'd10;
    end else if (r >= 5'd5) begin
      r = r - 5'd5;
    end
    r5 = r[3:0];
    if (r5[0] != x[0]) begin
      r5 = r5 + 4'd5;
    end
    return r5;
  endfunction

endpackage

>>> sv/three_digit_mux_display_scanner.sv
// ----------------------------------------------------------------------------
// three_digit_mux_display_scanner
// Three-digit multiplexed seven-segment scanner with decimal value load.
// ----------------------------------------------------------------------------
// Takes one beat per clock while s_axis_tready is high. A beat with tuser
// high loads a 16-bit value whose three low decimal digits (hundreds on
// digit 1) are shown; a beat with tuser low is a scan tick. Every beat gives
// one result beat: the one-hot digit enable (zero while blanking) and the
// segment pattern, a in bit 0. A beat passes the input register, then the
// result register, held under back-pressure while an empty input register
// still takes a beat. Register 0 sets the lit time and register 1 the blank
// time in ticks (0 counts as 256); a write restarts the scan at digit 1.
module three_digit_mux_display_scanner
  import tdmds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [15:0] value
  input  logic               s_axis_tuser,  // [0] kind: 1 load, 0 tick
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // [2:0] digit_enable, [9:3] segments
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  logic              in_valid_q;
  logic              in_kind_q;
  logic [ValueW-1:0] in_value_q;
  logic              out_valid_q;
  logic              out_free;
  logic              proc;

  logic [TimeW-1:0]  on_time_q,  on_time_d;
  logic [TimeW-1:0]  off_time_q, off_time_d;
  phase_e            phase_q,    phase_d;
  logic [TimeW-1:0]  lit_q,      lit_d;
  logic [TimeW-1:0]  gap_q,      gap_d;
  logic [DigitW-1:0] digits_q [NumDig];
  logic [DigitW-1:0] digits_d [NumDig];
  logic [SegW-1:0]   seg_q,      seg_d;
  logic [2:0]        en_q,       en_d;

  logic [32:0]       prod10;
  logic [28:0]       prod100;
  logic [ValueW-1:0] q10;
  logic [ValueW-1:0] q100;
  logic [TimeW-1:0]  lit_dec;
  logic [TimeW-1:0]  gap_dec;
  logic              cfg_hit;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, seg_q, en_q};

  // beat pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q  <= s_axis_tuser;
      in_value_q <= s_axis_tdata;
    end
  end

  // decimal split
  assign prod10  = 33'(in_value_q) * 33'(Recip10);
  assign prod100 = 29'(in_value_q[15:2]) * 29'(Recip25);
  assign q10     = ValueW'(prod10[31:RecipSh]);
  assign q100    = ValueW'(prod100[28:RecipSh]);

  assign lit_dec = lit_q - 8'd1;
  assign gap_dec = gap_q - 8'd1;
  assign cfg_hit = cfg_valid_i && (cfg_index_i == CfgOnTime || cfg_index_i == CfgOffTime);

  always_comb begin
    on_time_d  = on_time_q;
    off_time_d = off_time_q;
    phase_d    = phase_q;
    lit_d      = lit_q;
    gap_d      = gap_q;
    digits_d   = digits_q;
    seg_d      = seg_q;
    en_d       = en_q;

    if (proc) begin
      if (in_kind_q) begin
        digits_d[0] = dec_digit(q100);
        digits_d[1] = dec_digit(q10);
        digits_d[2] = dec_digit(in_value_q);
      end else begin
        unique case (phase_q)
          PH_GAP1, PH_GAP2, PH_GAP3: begin
            gap_d = gap_dec;
            en_d  = 3'b000;
            if (gap_dec == '0) begin
              lit_d = on_time_q;
              unique case (phase_q)
                PH_GAP1: phase_d = PH_DIGIT2;
                PH_GAP2: phase_d = PH_DIGIT3;
                default: phase_d = PH_DIGIT1;
              endcase
            end
          end
          PH_DIGIT2: begin
            lit_d = lit_dec;
            en_d  = 3'b010;
            seg_d = seg_pattern(digits_q[1]);
            if (lit_dec == '0) begin
              phase_d = PH_GAP2;
              gap_d   = off_time_q;
            end
          end
          PH_DIGIT3: begin
            lit_d = lit_dec;
            en_d  = 3'b100;
            seg_d = seg_pattern(digits_q[2]);
            if (lit_dec == '0) begin
              phase_d = PH_GAP3;
              gap_d   = off_time_q;
            end
          end
          default: begin
            lit_d = lit_dec;
            en_d  = 3'b001;
            seg_d = seg_pattern(digits_q[0]);
            if (lit_dec == '0) begin
              phase_d = PH_GAP1;
              gap_d   = off_time_q;
            end else begin
              phase_d = PH_DIGIT1;
            end
          end
        endcase
      end
    end

    // the user must write only while idle; the block does not enforce it
    if (cfg_hit) begin
      if (cfg_index_i == CfgOnTime) begin
        on_time_d = cfg_data_i;
        lit_d     = cfg_data_i;
        gap_d     = off_time_q;
      end else begin
        off_time_d = cfg_data_i;
        lit_d      = on_time_q;
        gap_d      = cfg_data_i;
      end
      phase_d = PH_DIGIT1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q  <= 8'd1;
      off_time_q <= 8'd1;
      phase_q    <= PH_DIGIT1;
      lit_q      <= 8'd1;
      gap_q      <= 8'd1;
      digits_q   <= '{default: '0};
      seg_q      <= '0;
      en_q       <= '0;
    end else begin
      on_time_q  <= on_time_d;
      off_time_q <= off_time_d;
      phase_q    <= phase_d;
      lit_q      <= lit_d;
      gap_q      <= gap_d;
      digits_q   <= digits_d;
      seg_q      <= seg_d;
      en_q       <= en_d;
    end
  end

endmodule
